// ===== src/assert_macros.svh =====
// assertion helpers for the rtl files; only additive_waveform_synth includes them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== src/aws_pkg.sv =====
package aws_pkg;

  // fixed field widths
  localparam int WORD_W      = 50;
  localparam int COUNT_W     = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int AMP_W       = 16;
  localparam int INC_W       = 32;
  localparam int WAVE_W      = 17;
  localparam int RECIP_W     = 17;

  // register indexes on the config port
  localparam logic [CFG_INDEX_W-1:0] REG_COUNT      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WORD_FIRST = 3'd1;
  localparam int                     WORD_REGS      = 4;

  // reset values: one sine at 440 Hz, amplitude 0.2
  localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd1;
  localparam logic [WORD_W-1:0]  WORD0_RESET = 50'd56298588798108;

  // quarter-wave sine table
  localparam int SINE_TABLE_BITS = 10;
  localparam int ROM_ENTRY_W     = 16;
  localparam int ROM_DEPTH       = (1 << SINE_TABLE_BITS) + 1;
  localparam int ROM_ADDR_W      = SINE_TABLE_BITS + 1;

  typedef logic [ROM_DEPTH*ROM_ENTRY_W-1:0] sine_rom_t;

  typedef enum logic [1:0] {
    WAVE_SINE,
    WAVE_SQUARE,
    WAVE_TRIANGLE,
    WAVE_SAW
  } wave_type_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_ACC,
    ST_MIX,
    ST_OUT
  } state_t;

  // q30 product truncated toward zero
  function automatic longint q30_mul(input longint a, input longint b);
    logic        neg;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] m;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? 64'(-a) : 64'(a);
    mb  = (b < 0) ? 64'(-b) : 64'(b);
    m   = (ma * mb) >> 30;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // one table entry from the odd taylor polynomial, q1.15
  function automatic logic [ROM_ENTRY_W-1:0] sine_entry(input int k);
    longint x;
    longint x2;
    longint p;
    longint y;
    x  = longint'(k) <<< (30 - SINE_TABLE_BITS);
    x2 = q30_mul(x, x);
    p  = 172272;
    p  = -5026994 + q30_mul(p, x2);
    p  = 85569306 + q30_mul(p, x2);
    p  = -693598668 + q30_mul(p, x2);
    p  = 1686629713 + q30_mul(p, x2);
    y  = q30_mul(p, x);
    if (y < 0) y = 0;
    y = (y + 16384) >>> 15;
    if (y > 32768) y = 32768;
    return ROM_ENTRY_W'(y);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t r;
    r = '0;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      r[k*ROM_ENTRY_W +: ROM_ENTRY_W] = sine_entry(k);
    end
    return r;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // rounded 65536 / count, zero for silence
  function automatic logic [RECIP_W-1:0] recip_of(input logic [COUNT_W-1:0] count);
    logic [RECIP_W-1:0] r;
    case (count)
      3'd0: r = 17'd0;
      3'd1: r = 17'd65536;
      3'd2: r = 17'd32768;
      3'd3: r = 17'd21845;
      3'd4: r = 17'd16384;
      3'd5: r = 17'd13107;
      3'd6: r = 17'd10923;
      3'd7: r = 17'd9362;
    endcase
    return r;
  endfunction

endpackage

// ===== src/additive_waveform_synth.sv =====
// Additive oscillator bank: each accepted word on the slave stream is one
// sample tick and yields one mixed sample on the master stream. Components
// are visited one after another through a single shared multiplier (wave
// times amplitude, then the sum times the reciprocal of the count). Each
// component passes ST_LOAD, ST_MUL and ST_ACC in turn, then ST_MIX applies
// the normalization and ST_OUT registers the output; ready returns in
// ST_IDLE after that. The output register holds a finished sample while the
// next tick is accepted; a tick only waits at its end if the previous sample
// has not been taken. Setting bit 0 of the input word zeroes all phase
// accumulators before that tick. Config writes are always accepted and are
// meant to happen while the block is idle.
module additive_waveform_synth #(
  parameter int NUM_COMPONENTS = 4,
  parameter int PHASE_BITS     = 32,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // config write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [aws_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [aws_pkg::WORD_W-1:0]            cfg_data,
  // slave stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [7:0]                            s_axis_tdata,  // [0] restart
  // master stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_axis_tdata,  // sample
  output logic                                  m_axis_tuser   // [0] clipped
);
  import aws_pkg::*;

  localparam int IDX_W     = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;
  localparam int OUT_W     = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int PROD_W    = WAVE_W + AMP_W;
  localparam int SUM_W     = PROD_W + $clog2(NUM_COMPONENTS + 1);
  localparam int MUL_B_W   = AMP_W + 2;
  localparam int MUL_W     = SUM_W + MUL_B_W;
  localparam int MIX_SHIFT = 46 - SAMPLE_BITS;

  localparam logic signed [MUL_W:0] RND_BIAS =
    {{(MUL_W + 1 - MIX_SHIFT){1'b0}}, 1'b1, {(MIX_SHIFT - 1){1'b0}}};
  localparam logic signed [MUL_W:0] SMAX = (MUL_W + 1)'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [MUL_W:0] SMIN = ~SMAX;

  state_t                    state;
  state_t                    state_next;

  logic [COUNT_W-1:0]        count;
  logic [WORD_W-1:0]         words [NUM_COMPONENTS];
  logic [PHASE_BITS-1:0]     accs  [NUM_COMPONENTS];

  logic [IDX_W-1:0]          comp;
  logic signed [SUM_W-1:0]   sum;
  logic signed [MUL_W-1:0]   mul_q;
  logic [SAMPLE_BITS-1:0]    sample_q;
  logic                      clip_q;

  logic                      in_accept;
  logic                      wave_load;
  logic                      out_load;
  logic                      comp_last;
  logic                      comp_active;

  logic [COUNT_W-1:0]        count_eff;
  logic [WORD_W-1:0]         cur_word;
  logic [PHASE_BITS+INC_W-1:0] inc_ext;
  logic [PHASE_BITS-1:0]     inc;
  logic signed [WAVE_W-1:0]  wave;

  logic signed [SUM_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0] mul_b;

  logic signed [MUL_W:0]     rnd;
  logic signed [MUL_W:0]     shifted;
  logic                      clip_hi;
  logic                      clip_lo;
  logic [SAMPLE_BITS-1:0]    sample_sat;

  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= COUNT_RESET;
      for (int j = 0; j < NUM_COMPONENTS; j++) begin
        words[j] <= (j == 0) ? WORD0_RESET : '0;
      end
    end else if (cfg_valid) begin
      if (cfg_index == REG_COUNT) begin
        count <= cfg_data[COUNT_W-1:0];
      end
      for (int j = 0; j < NUM_COMPONENTS; j++) begin
        if (j < WORD_REGS && cfg_index == CFG_INDEX_W'(j) + REG_WORD_FIRST) begin
          words[j] <= cfg_data;
        end
      end
    end
  end

  // per-component selection
  always_comb begin
    count_eff   = (int'(count) > NUM_COMPONENTS) ? COUNT_W'(NUM_COMPONENTS) : count;
    cur_word    = words[comp];
    inc_ext     = {{PHASE_BITS{1'b0}}, cur_word[INC_W+1:2]};
    inc         = inc_ext[PHASE_BITS-1:0];
    comp_last   = (comp == IDX_W'(NUM_COMPONENTS - 1));
    comp_active = (int'(comp) < int'(count_eff));
  end

  aws_wave_gen #(
    .PHASE_BITS (PHASE_BITS)
  ) u_wave_gen (
    .clk       (clk),
    .load      (wave_load),
    .phase     (accs[comp]),
    .wave_type (wave_type_t'(cur_word[1:0])),
    .wave      (wave)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_axis_tvalid) state_next = ST_LOAD;
      ST_LOAD: state_next = ST_MUL;
      ST_MUL:  state_next = ST_ACC;
      ST_ACC:  state_next = comp_last ? ST_MIX : ST_LOAD;
      ST_MIX:  state_next = ST_OUT;
      ST_OUT:  if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    wave_load     = (state == ST_LOAD);
    out_load      = (state == ST_OUT) && (!m_axis_tvalid || m_axis_tready);
    in_accept     = s_axis_tvalid && s_axis_tready;
  end

  // shared multiplier operands
  always_comb begin
    if (state == ST_MIX) begin
      mul_a = sum;
      mul_b = $signed({1'b0, recip_of(count_eff)});
    end else begin
      mul_a = SUM_W'(wave);
      mul_b = $signed({2'b00, cur_word[WORD_W-1 -: AMP_W]});
    end
  end

  // phase accumulators, cleared on restart, stepped as each component is read
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NUM_COMPONENTS; j++) accs[j] <= '0;
    end else if (in_accept && s_axis_tdata[0]) begin
      for (int j = 0; j < NUM_COMPONENTS; j++) accs[j] <= '0;
    end else if (wave_load) begin
      accs[comp] <= accs[comp] + inc;
    end
  end

  // component counter and mix datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      comp <= '0;
    end else if (in_accept) begin
      comp <= '0;
    end else if (state == ST_ACC && !comp_last) begin
      comp <= comp + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sum <= '0;
    end else if (state == ST_ACC && comp_active) begin
      sum <= sum + $signed(mul_q[SUM_W-1:0]);
    end
    if (state == ST_MUL || state == ST_MIX) begin
      mul_q <= mul_a * mul_b;
    end
  end

  // round half up and saturate
  always_comb begin
    rnd        = $signed({mul_q[MUL_W-1], mul_q}) + RND_BIAS;
    shifted    = rnd >>> MIX_SHIFT;
    clip_hi    = shifted > SMAX;
    clip_lo    = shifted < SMIN;
    if (clip_hi) begin
      sample_sat = SMAX[SAMPLE_BITS-1:0];
    end else if (clip_lo) begin
      sample_sat = SMIN[SAMPLE_BITS-1:0];
    end else begin
      sample_sat = shifted[SAMPLE_BITS-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample_q <= sample_sat;
      clip_q   <= clip_hi || clip_lo;
    end
  end

  assign m_axis_tdata = OUT_W'(sample_q);
  assign m_axis_tuser = clip_q;

`include "assert_macros.svh"

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_accept, !s_axis_tready, "ready after accept")
  `ASSERT_ALWAYS(a_comp_range, clk, rst, int'(comp) < NUM_COMPONENTS, "component index overrun")
  `ASSERT_NEXT(a_silent_count, clk, rst, out_load && (count_eff == '0),
    (sample_q == '0) && !clip_q, "nonzero output with no components")
  `ASSERT_ALWAYS(a_clip_at_rail, clk, rst, !(m_axis_tvalid && clip_q) ||
    (sample_q == SMAX[SAMPLE_BITS-1:0]) || (sample_q == SMIN[SAMPLE_BITS-1:0]),
    "clip flag off the rail")

endmodule

// ===== src/aws_wave_gen.sv =====
module aws_wave_gen #(
  parameter int PHASE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic [PHASE_BITS-1:0]         phase,
  input  aws_pkg::wave_type_t           wave_type,
  output logic signed [aws_pkg::WAVE_W-1:0] wave
);
  import aws_pkg::*;

  logic [1:0]                  quad;
  logic [SINE_TABLE_BITS-1:0]  k;
  logic [ROM_ADDR_W-1:0]       rom_addr;

  logic                        neg_q;
  logic [15:0]                 h_q;
  logic [ROM_ENTRY_W-1:0]      rom_q;
  wave_type_t                  type_q;

  logic signed [WAVE_W-1:0]    mag;
  logic signed [WAVE_W-1:0]    tw;
  logic signed [WAVE_W-1:0]    pos_full;
  logic signed [WAVE_W-1:0]    neg_full;

  // table address, mirrored in odd quadrants
  always_comb begin
    quad     = phase[PHASE_BITS-1 -: 2];
    k        = phase[PHASE_BITS-3 -: SINE_TABLE_BITS];
    rom_addr = quad[0] ? ROM_ADDR_W'(ROM_DEPTH - 1) - {1'b0, k} : {1'b0, k};
  end

  // registered table read and phase fields
  always_ff @(posedge clk) begin
    if (load) begin
      rom_q  <= SINE_ROM[32'(rom_addr) * ROM_ENTRY_W +: ROM_ENTRY_W];
      neg_q  <= quad[1];
      h_q    <= phase[PHASE_BITS-1 -: 16];
      type_q <= wave_type;
    end
  end

  // wave shaping from the registered values
  always_comb begin
    mag      = $signed({1'b0, rom_q});
    tw       = $signed({h_q, 1'b0});
    pos_full = $signed(17'h08000);
    neg_full = $signed(17'h18000);
    case (type_q)
      WAVE_SINE:   wave = neg_q ? -mag : mag;
      WAVE_SQUARE: wave = (!neg_q && (rom_q != '0)) ? pos_full : neg_full;
      WAVE_TRIANGLE: begin
        // low 17 bits of 2h, 65536-2h or 2h-131072
        if (h_q >= 16'd16384 && h_q < 16'd49152) begin
          wave = $signed(17'h10000 - {h_q, 1'b0});
        end else begin
          wave = tw;
        end
      end
      WAVE_SAW:    wave = $signed({h_q[15], h_q});
    endcase
  end

endmodule
